// File: hw/rtl/smbs_pkg.sv
// Package for the SPI master byte shifter: word size, register indexes,
// phase encoding and the per-tick result record.
// Depends on nothing; every file of the block imports it.
package smbs_pkg;

    // Bits shifted per SPI word and the width of the bit counter.
    localparam int WORD_BITS = 8;
    localparam int CNT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DELAY_W    = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_POLARITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_DELAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETUP_DELAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY   = 3'd4;

    // Sequencer phases, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SELECT = 4'b0010,
        PH_SETUP  = 4'b0100,
        PH_ASSERT = 4'b1000
    } phase_t;

    // One result per tick.
    typedef struct packed {
        logic       sck_level;
        logic       mosi_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
    } result_t;

endpackage

// File: hw/rtl/smbs_out_skid.sv
// Output stage of the SPI master byte shifter: a result register with a
// one-entry skid register, so a tick is taken while a result waits.
// Depends on smbs_pkg for the result record.
module smbs_out_skid
    import smbs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    in_fire;

    // The skid entry is the only thing that can hold off the input side.
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control: refill the output register from the skid first, else from the input.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload follows the same selection and needs no reset.
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_fire) begin
                out_data_reg <= in_data;
            end
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// File: hw/rtl/spi_master_byte_shifter_unit.sv
// Top level of the tick-driven SPI master byte shifter: configuration
// registers, the phase sequencer and the output stage.
// Depends on smbs_pkg and smbs_out_skid.
//
// Each input item is one tick of the pin-level SPI sequencer. The pin
// levels, busy, done and received byte of a taken tick are registered in
// the output register; one tick is taken every cycle for as long as the
// output side keeps up, and the one-entry skid register lets one further
// tick in while a result is held. A transfer
// started by a tick with mode set lasts select_delay + 1 ticks followed, for
// each of the eight bits, by setup_delay + 1 and sample_delay + 1 ticks.
// Configuration writes take effect on the next clock; delay changes apply
// the next time a phase is entered, polarity and bit order at once.
module spi_master_byte_shifter_unit
    import smbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Tick input channel.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [7:0]            s_tx_byte,
    input  logic                  s_miso_level,
    // Result channel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_sck_level,
    output logic                  m_mosi_level,
    output logic                  m_busy_res,
    output logic                  m_done_res,
    output logic [7:0]            m_rx_byte
);

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WORD_BITS - 1);

    // Configuration registers.
    logic               clock_polarity_reg;
    logic               lsb_first_reg;
    logic [DELAY_W-1:0] select_delay_reg;
    logic [DELAY_W-1:0] setup_delay_reg;
    logic [DELAY_W-1:0] sample_delay_reg;

    // Sequencer state.
    phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]     bit_count_reg, bit_count_next;
    logic [DELAY_W-1:0]   wait_count_reg, wait_count_next;
    logic [WORD_BITS-1:0] tx_shift_reg, tx_shift_next;
    logic [WORD_BITS-1:0] rx_shift_reg, rx_shift_next;
    logic [WORD_BITS-1:0] rx_hold_reg, rx_hold_next;
    logic                 mosi_out_reg, mosi_out_next;

    logic             s_fire;
    logic             done_next;
    logic [CNT_W-1:0] bit_pos;
    logic [CNT_W-1:0] next_pos;
    result_t          result_next;
    result_t          result_out;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_polarity_reg <= 1'b0;
            lsb_first_reg      <= 1'b0;
            select_delay_reg   <= DELAY_W'(1);
            setup_delay_reg    <= DELAY_W'(1);
            sample_delay_reg   <= DELAY_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CLOCK_POLARITY: clock_polarity_reg <= cfg_wdata[0];
                REG_LSB_FIRST:      lsb_first_reg      <= cfg_wdata[0];
                REG_SELECT_DELAY:   select_delay_reg   <= cfg_wdata[DELAY_W-1:0];
                REG_SETUP_DELAY:    setup_delay_reg    <= cfg_wdata[DELAY_W-1:0];
                REG_SAMPLE_DELAY:   sample_delay_reg   <= cfg_wdata[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_fire = s_valid && s_ready;

    // Bit position of the current bit and of the one after it, in the live order.
    assign bit_pos  = lsb_first_reg ? bit_count_reg : (LAST_BIT - bit_count_reg);
    assign next_pos = lsb_first_reg ? (bit_count_reg + CNT_W'(1))
                                    : (LAST_BIT - bit_count_reg - CNT_W'(1));

    // Phase sequencer: one step per tick.
    always_comb begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        wait_count_next = wait_count_reg;
        tx_shift_next   = tx_shift_reg;
        rx_shift_next   = rx_shift_reg;
        rx_hold_next    = rx_hold_reg;
        mosi_out_next   = mosi_out_reg;
        done_next       = 1'b0;
        if (phase_reg == PH_IDLE) begin
            if (s_mode) begin
                tx_shift_next   = WORD_BITS'(s_tx_byte);
                rx_shift_next   = '0;
                bit_count_next  = '0;
                wait_count_next = select_delay_reg;
                phase_next      = PH_SELECT;
            end
        end else if (wait_count_reg != '0) begin
            wait_count_next = wait_count_reg - DELAY_W'(1);
        end else begin
            case (phase_reg)
                PH_SELECT: begin
                    mosi_out_next   = tx_shift_reg[bit_pos];
                    wait_count_next = setup_delay_reg;
                    phase_next      = PH_SETUP;
                end
                PH_SETUP: begin
                    wait_count_next = sample_delay_reg;
                    phase_next      = PH_ASSERT;
                end
                PH_ASSERT: begin
                    // Each sampled bit lands at its own position only.
                    rx_shift_next[bit_pos] = s_miso_level;
                    if (bit_count_reg == LAST_BIT) begin
                        rx_hold_next   = rx_shift_next;
                        bit_count_next = '0;
                        phase_next     = PH_IDLE;
                        done_next      = 1'b1;
                    end else begin
                        bit_count_next  = bit_count_reg + CNT_W'(1);
                        mosi_out_next   = tx_shift_reg[next_pos];
                        wait_count_next = setup_delay_reg;
                        phase_next      = PH_SETUP;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // State advances only on an input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            wait_count_reg <= '0;
            tx_shift_reg   <= '0;
            rx_shift_reg   <= '0;
            rx_hold_reg    <= '0;
            mosi_out_reg   <= 1'b0;
        end else if (s_fire) begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            wait_count_reg <= wait_count_next;
            tx_shift_reg   <= tx_shift_next;
            rx_shift_reg   <= rx_shift_next;
            rx_hold_reg    <= rx_hold_next;
            mosi_out_reg   <= mosi_out_next;
        end
    end

    // Pin levels and status as they stand after this tick.
    always_comb begin
        result_next.sck_level  = (phase_next == PH_ASSERT) ? !clock_polarity_reg
                                                           : clock_polarity_reg;
        result_next.mosi_level = mosi_out_next;
        result_next.busy_res   = (phase_next != PH_IDLE);
        result_next.done_res   = done_next;
        result_next.rx_byte    = 8'(rx_hold_next);
    end

    smbs_out_skid u_out_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (result_next),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (result_out)
    );

    assign m_sck_level  = result_out.sck_level;
    assign m_mosi_level = result_out.mosi_level;
    assign m_busy_res   = result_out.busy_res;
    assign m_done_res   = result_out.done_res;
    assign m_rx_byte    = result_out.rx_byte;

    // A tick that completes a word leaves the sequencer idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && done_next) |=> (phase_reg == PH_IDLE))
        else $error("sequencer not idle after the last bit");

    // Without an input transfer the sequencer holds still.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> ($stable(phase_reg) && $stable(wait_count_reg)
                     && $stable(bit_count_reg)))
        else $error("sequencer moved without an input transfer");

    // A done result never reports busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> !m_busy_res)
        else $error("done result reported as busy");

endmodule

// File: tb/tb.sv
// Testbench for the SPI master byte shifter: drives ticks through the input channel,
// predicts the pin levels, busy, done and received byte of every tick, and checks each result.
// Depends on smbs_pkg and spi_master_byte_shifter_unit.
module tb
    import smbs_pkg::*;
();

    class spi_pin_scoreboard;
        // Live configuration, as last written.
        bit               cpol;
        bit               lsb_first;
        bit [DELAY_W-1:0] select_dly;
        bit [DELAY_W-1:0] setup_dly;
        bit [DELAY_W-1:0] sample_dly;
        // Sequencer state of the predicted shifter.
        phase_t           phase;
        bit [CNT_W-1:0]   bit_idx;
        bit [DELAY_W-1:0] wait_cnt;
        bit [7:0]         tx_word;
        bit [7:0]         rx_word;
        bit [7:0]         rx_latched;
        bit               mosi;
        // Pin levels expected for ticks already taken, oldest first.
        result_t          expected_pins_q[$];
        int               results_seen;
        int               mismatches;

        function new();
            cpol         = 1'b0;
            lsb_first    = 1'b0;
            select_dly   = DELAY_W'(1);
            setup_dly    = DELAY_W'(1);
            sample_dly   = DELAY_W'(1);
            phase        = PH_IDLE;
            bit_idx      = '0;
            wait_cnt     = '0;
            tx_word      = '0;
            rx_word      = '0;
            rx_latched   = '0;
            mosi         = 1'b0;
            results_seen = 0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_CLOCK_POLARITY: cpol       = value[0];
                REG_LSB_FIRST:      lsb_first  = value[0];
                REG_SELECT_DELAY:   select_dly = value[DELAY_W-1:0];
                REG_SETUP_DELAY:    setup_dly  = value[DELAY_W-1:0];
                REG_SAMPLE_DELAY:   sample_dly = value[DELAY_W-1:0];
                default: ;
            endcase
        endfunction

        // The bit position follows the live bit order, not the order at the start.
        function int bit_pos();
            return lsb_first ? int'(bit_idx) : WORD_BITS - 1 - int'(bit_idx);
        endfunction

        function void drive_bit();
            mosi     = tx_word[bit_pos()];
            wait_cnt = setup_dly;
            phase    = PH_SETUP;
        endfunction

        // Advance the predicted shifter by one accepted tick and queue its pin levels.
        function void note_tick(bit start, bit [7:0] tx, bit miso);
            result_t pins;
            bit      done;
            done = 1'b0;
            if (phase == PH_IDLE) begin
                if (start) begin
                    tx_word  = tx;
                    rx_word  = '0;
                    bit_idx  = '0;
                    wait_cnt = select_dly;
                    phase    = PH_SELECT;
                end
            end else if (wait_cnt != 0) begin
                wait_cnt = wait_cnt - 1'b1;
            end else if (phase == PH_SELECT) begin
                drive_bit();
            end else if (phase == PH_SETUP) begin
                wait_cnt = sample_dly;
                phase    = PH_ASSERT;
            end else begin
                // Each sampled bit lands at its own position only.
                rx_word[bit_pos()] = miso;
                if (int'(bit_idx) >= WORD_BITS - 1) begin
                    rx_latched = rx_word;
                    bit_idx    = '0;
                    phase      = PH_IDLE;
                    done       = 1'b1;
                end else begin
                    bit_idx = bit_idx + 1'b1;
                    drive_bit();
                end
            end
            pins.sck_level  = (phase == PH_ASSERT) ? ~cpol : cpol;
            pins.mosi_level = mosi;
            pins.busy_res   = (phase != PH_IDLE);
            pins.done_res   = done;
            pins.rx_byte    = rx_latched;
            expected_pins_q.push_back(pins);
        endfunction

        task report(string msg);
            $display("error: result %0d: %s", results_seen, msg);
            mismatches++;
        endtask

        // Compare one result with the oldest expectation, field by field.
        task check_pins(result_t got);
            result_t want;
            results_seen++;
            if (expected_pins_q.size() == 0) begin
                report($sformatf("result %h arrived with no tick outstanding", got));
                return;
            end
            want = expected_pins_q.pop_front();
            if (got.sck_level !== want.sck_level)
                report($sformatf("sck_level %b, expected %b", got.sck_level, want.sck_level));
            if (got.mosi_level !== want.mosi_level)
                report($sformatf("mosi_level %b, expected %b", got.mosi_level,
                                 want.mosi_level));
            if (got.busy_res !== want.busy_res)
                report($sformatf("busy_res %b, expected %b", got.busy_res, want.busy_res));
            if (got.done_res !== want.done_res)
                report($sformatf("done_res %b, expected %b", got.done_res, want.done_res));
            if (got.rx_byte !== want.rx_byte)
                report($sformatf("rx_byte %h, expected %h", got.rx_byte, want.rx_byte));
        endtask
    endclass

    localparam logic [7:0] MISO_PATTERN = 8'b1011_0010;

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_mode       = 1'b0;
    logic [7:0]            s_tx_byte    = '0;
    logic                  s_miso_level = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic                  m_sck_level;
    logic                  m_mosi_level;
    logic                  m_busy_res;
    logic                  m_done_res;
    logic [7:0]            m_rx_byte;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    spi_pin_scoreboard sb;

    spi_master_byte_shifter_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_tx_byte    (s_tx_byte),
        .s_miso_level (s_miso_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sck_level  (m_sck_level),
        .m_mosi_level (m_mosi_level),
        .m_busy_res   (m_busy_res),
        .m_done_res   (m_done_res),
        .m_rx_byte    (m_rx_byte)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result side stalls at random, at the rate of the current stage.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every result transfer against the prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_pins(result_t'({m_sck_level, m_mosi_level, m_busy_res, m_done_res,
                                     m_rx_byte}));
    end

    // Offer one tick, with a random gap first, and note it once the transfer happens.
    task automatic send_tick(bit mode, bit [7:0] tx, bit miso);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_tx_byte    <= tx;
        s_miso_level <= miso;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_tick(mode, tx, miso);
    endtask

    // Wait until every tick has produced its result and the output stage is empty.
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (sb.expected_pins_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge aclk);
    endtask

    // Mostly short delays, so that many bytes complete; now and then a longer one.
    task automatic random_settings();
        write_reg(REG_CLOCK_POLARITY, CFG_DATA_W'($urandom_range(1)));
        write_reg(REG_LSB_FIRST, CFG_DATA_W'($urandom_range(1)));
        write_reg(REG_SELECT_DELAY,
                  CFG_DATA_W'(($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3)));
        write_reg(REG_SETUP_DELAY,
                  CFG_DATA_W'(($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3)));
        write_reg(REG_SAMPLE_DELAY,
                  CFG_DATA_W'(($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3)));
    endtask

    // Starts are likely when idle; while busy a few stray starts test that they are dropped.
    task automatic random_ticks(int count);
        bit mode;
        repeat (count) begin
            if (sb.phase == PH_IDLE)
                mode = ($urandom_range(3) != 0);
            else
                mode = ($urandom_range(7) == 0);
            send_tick(mode, 8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Plain ticks show the reset pin levels.
        send_tick(1'b0, 8'hFF, 1'b1);
        send_tick(1'b0, 8'h00, 1'b0);
        drain_and_settle();

        // Zero delays and a start on every tick: starts while busy and in the done
        // tick are dropped, and the tick after done starts the next byte.
        write_reg(REG_CLOCK_POLARITY, '0);
        write_reg(REG_LSB_FIRST, '0);
        write_reg(REG_SELECT_DELAY, '0);
        write_reg(REG_SETUP_DELAY, '0);
        write_reg(REG_SAMPLE_DELAY, '0);
        for (int i = 0; i < 22; i++)
            send_tick(1'b1, (i == 0) ? 8'hA5 : 8'hFF, MISO_PATTERN[i % 8]);

        // Random part: sender idles rarely, then receiver idles rarely, then neither.
        // Settings change between batches, often in the middle of a byte.
        for (int stage = 0; stage < 3; stage++) begin
            send_idle_pct = (stage == 0) ? 13 : (stage == 1) ? 81 : 0;
            recv_idle_pct = (stage == 0) ? 81 : (stage == 1) ? 13 : 0;
            repeat (4) begin
                drain_and_settle();
                random_settings();
                random_ticks(88);
            end
        end

        // Long delays: run one byte through select with a count above eight bits and through setup,
        // then switch to zero delays, opposite polarity and order during the sample wait.
        while (sb.phase != PH_IDLE) send_tick(1'b0, 8'($urandom), 1'($urandom));
        drain_and_settle();
        write_reg(REG_SELECT_DELAY, 16'h0100);
        write_reg(REG_SETUP_DELAY, 16'h0020);
        write_reg(REG_SAMPLE_DELAY, 16'h0020);
        send_tick(1'b1, 8'($urandom), 1'($urandom));
        while (sb.phase != PH_ASSERT) send_tick(1'b0, 8'($urandom), 1'($urandom));
        drain_and_settle();
        write_reg(REG_CLOCK_POLARITY, CFG_DATA_W'(!sb.cpol));
        write_reg(REG_LSB_FIRST, CFG_DATA_W'(!sb.lsb_first));
        write_reg(REG_SELECT_DELAY, '0);
        write_reg(REG_SETUP_DELAY, '0);
        write_reg(REG_SAMPLE_DELAY, '0);
        while (sb.phase != PH_IDLE) send_tick(1'b0, 8'($urandom), 1'($urandom));

        drain_and_settle();
        repeat (4) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #12_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
